[hw/rtl/bpin_pkg.sv]
`default_nettype none

package bpin_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [7:0] FirstCodeReset = 8'h41;
  localparam logic [7:0] UpperA = 8'h41;
  localparam logic [7:0] UpperZ = 8'h5a;
  localparam logic [7:0] LowerA = 8'h61;
  localparam logic [7:0] LowerZ = 8'h7a;
  localparam logic [7:0] CaseOffset = 8'h20;
  localparam logic [7:0] SpaceByte = 8'h20;

  typedef logic [15:0] pair_key_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    if (b >= UpperA && b <= UpperZ) begin
      return b + CaseOffset;
    end
    return b;
  endfunction

  function automatic logic is_lower(input logic [7:0] b);
    return (b >= LowerA) && (b <= LowerZ);
  endfunction

  function automatic logic [7:0] code_of(input logic [7:0] base, input logic [CntW-1:0] idx);
    logic [CntW+7:0] sum;
    sum = {{CntW{1'b0}}, base} + {8'b0, idx};
    return sum[7:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/byte_pair_interning_normaliser_core.sv]
// Byte-pair interning normaliser.
// Input channel: in_valid_i / in_stall_o carries one raw byte and a last flag.
// A request is taken when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i carries the normalised byte with
// new_entry_o, table_full_o and out_last_o; the receiver holds it with stall.
// ASCII A-Z fold to a-z; lowercase letters and a lone final byte pass on
// as results. Any other byte opens a pair and gives no result by itself.
// The byte closing a pair starts a scan of the pair table: one stored entry
// is read per cycle from a single-port memory and checked by one comparator;
// a miss stores the pair at the next free entry; a full table gives a space.
// Codes are first_code plus the entry index, worked out at lookup time.
// The input stalls while a scan runs or a result waits for the output slot;
// the output register holds a stalled result, so one result can wait there
// while the next request is taken.
// Reset empties the table (entry count zero), drops an open pair and sets
// first_code to 0x41. cfg_we_i writes first_code at any edge.
`default_nettype none

module byte_pair_interning_normaliser_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            new_entry_o,
  output logic            table_full_o,
  output logic            out_last_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StHold = 3'b100
  } state_e;

  localparam int unsigned IdxW = bpin_pkg::IdxW;
  localparam int unsigned CntW = bpin_pkg::CntW;

  state_e state_q, state_d;
  logic [7:0] first_code_q;
  logic [CntW-1:0] count_q, count_d;
  logic pend_valid_q, pend_valid_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  bpin_pkg::pair_key_t key_q, key_d;
  logic key_last_q, key_last_d;
  logic [CntW-1:0] scan_idx_q, scan_idx_d;
  logic [CntW-1:0] cmp_idx_q, cmp_idx_d;
  logic cmp_valid_q, cmp_valid_d;
  bpin_pkg::pair_key_t rd_data_q;
  logic rd_en;
  logic wr_en;

  logic [7:0] res_byte_q, res_byte_d;
  logic res_new_q, res_new_d;
  logic res_full_q, res_full_d;
  logic res_last_q, res_last_d;

  logic out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic out_new_q, out_full_q, out_last_q;
  logic out_free, out_load, in_take, hit;
  logic [7:0] folded;

  bpin_pkg::pair_key_t table_mem [bpin_pkg::TableDepth];

  assign folded = bpin_pkg::fold_byte(in_byte_i);
  assign in_stall_o = (state_q != StIdle);
  assign in_take = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign hit = cmp_valid_q && (rd_data_q == key_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pend_valid_d = pend_valid_q;
    pend_byte_d = pend_byte_q;
    key_d = key_q;
    key_last_d = key_last_q;
    scan_idx_d = scan_idx_q;
    cmp_idx_d = cmp_idx_q;
    cmp_valid_d = 1'b0;
    res_byte_d = res_byte_q;
    res_new_d = res_new_q;
    res_full_d = res_full_q;
    res_last_d = res_last_q;
    rd_en = 1'b0;
    wr_en = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_take) begin
          if (pend_valid_q) begin
            pend_valid_d = 1'b0;
            key_d = {pend_byte_q, folded};
            key_last_d = in_last_i;
            scan_idx_d = '0;
            state_d = StScan;
          end else if (bpin_pkg::is_lower(folded) || in_last_i) begin
            res_byte_d = folded;
            res_new_d = 1'b0;
            res_full_d = 1'b0;
            res_last_d = in_last_i;
            state_d = StHold;
          end else begin
            pend_valid_d = 1'b1;
            pend_byte_d = folded;
          end
        end
      end
      StScan: begin
        res_last_d = key_last_q;
        if (hit) begin
          res_byte_d = bpin_pkg::code_of(first_code_q, cmp_idx_q);
          res_new_d = 1'b0;
          res_full_d = 1'b0;
          state_d = StHold;
        end else if (scan_idx_q < count_q) begin
          rd_en = 1'b1;
          cmp_valid_d = 1'b1;
          cmp_idx_d = scan_idx_q;
          scan_idx_d = scan_idx_q + 1'b1;
        end else if (count_q == CntW'(bpin_pkg::TableDepth)) begin
          res_byte_d = bpin_pkg::SpaceByte;
          res_new_d = 1'b0;
          res_full_d = 1'b1;
          state_d = StHold;
        end else begin
          wr_en = 1'b1;
          res_byte_d = bpin_pkg::code_of(first_code_q, count_q);
          res_new_d = 1'b1;
          res_full_d = 1'b0;
          count_d = count_q + 1'b1;
          state_d = StHold;
        end
      end
      StHold: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      first_code_q <= bpin_pkg::FirstCodeReset;
      count_q <= '0;
      pend_valid_q <= 1'b0;
      pend_byte_q <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        first_code_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      pend_valid_q <= pend_valid_d;
      pend_byte_q <= pend_byte_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    key_last_q <= key_last_d;
    scan_idx_q <= scan_idx_d;
    cmp_idx_q <= cmp_idx_d;
    res_byte_q <= res_byte_d;
    res_new_q <= res_new_d;
    res_full_q <= res_full_d;
    res_last_q <= res_last_d;
    if (out_load) begin
      out_byte_q <= res_byte_q;
      out_new_q <= res_new_q;
      out_full_q <= res_full_q;
      out_last_q <= res_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[count_q[IdxW-1:0]] <= key_q;
    end
    if (rd_en) begin
      rd_data_q <= table_mem[scan_idx_q[IdxW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o = out_byte_q;
  assign new_entry_o = out_new_q;
  assign table_full_o = out_full_q;
  assign out_last_o = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/bpin_checker.sv]
`default_nettype none

module bpin_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       in_last_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       new_entry_o,
  input wire logic       table_full_o,
  input wire logic       out_last_o
);

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("stalled result dropped");

  property p_out_stable;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=>
        $stable(out_byte_o) && $stable(new_entry_o) && $stable(table_full_o)
        && $stable(out_last_o);
  endproperty
  a_out_stable: assert property (p_out_stable) else $error("stalled result changed");

  property p_full_space;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && table_full_o |-> (out_byte_o == 8'h20) && !new_entry_o;
  endproperty
  a_full_space: assert property (p_full_space) else $error("full result malformed");

  property p_last_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && !in_stall_o && in_last_i |=> in_stall_o;
  endproperty
  a_last_busy: assert property (p_last_busy) else $error("final byte gave no work");

endmodule

bind byte_pair_interning_normaliser_core bpin_checker u_bpin_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .in_last_i    (in_last_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_o   (out_byte_o),
  .new_entry_o  (new_entry_o),
  .table_full_o (table_full_o),
  .out_last_o   (out_last_o)
);

`default_nettype wire
